// ===== design/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, register map constants and byte access functions for the status
// register window of the I2C master.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // byte address of the first location past the register map
  localparam logic [6:0] WINDOW_END = 7'h24;

  // register slots, one per 32-bit stride
  localparam logic [4:0] SLOT_CR1   = 5'd0;
  localparam logic [4:0] SLOT_CR2   = 5'd1;
  localparam logic [4:0] SLOT_OAR1  = 5'd2;
  localparam logic [4:0] SLOT_OAR2  = 5'd3;
  localparam logic [4:0] SLOT_DR    = 5'd4;
  localparam logic [4:0] SLOT_SR1   = 5'd5;
  localparam logic [4:0] SLOT_SR2   = 5'd6;
  localparam logic [4:0] SLOT_CCR   = 5'd7;
  localparam logic [4:0] SLOT_TRISE = 5'd8;

  // control one bits
  localparam logic [15:0] CR_START = 16'h0100;
  localparam logic [15:0] CR_STOP  = 16'h0200;

  // status one bits
  localparam logic [15:0] S1_SB    = 16'h0001;
  localparam logic [15:0] S1_ADDR  = 16'h0002;
  localparam logic [15:0] S1_BTF   = 16'h0004;
  localparam logic [15:0] S1_STOPF = 16'h0010;
  localparam logic [15:0] S1_TXE   = 16'h0080;

  // status two bits
  localparam logic [15:0] S2_MSL  = 16'h0001;
  localparam logic [15:0] S2_BUSY = 16'h0002;
  localparam logic [15:0] S2_TRA  = 16'h0004;

  // most bytes in one access
  localparam logic [2:0] MAX_BYTES = 3'd4;

  typedef struct packed {
    logic        wr;
    logic [5:0]  offset;
    logic [2:0]  nbytes;
    logic [31:0] wdata;
  } access_t;

  typedef struct packed {
    logic [15:0] cr1;
    logic [15:0] cr2;
    logic [15:0] oar1;
    logic [15:0] oar2;
    logic [7:0]  dr;
    logic [15:0] sr1;
    logic [15:0] sr2;
    logic [15:0] ccr;
    logic [15:0] trise;
    logic        start_w;
    logic        addr_ph;
    logic        stop_w;
  } regs_t;

  typedef struct packed {
    regs_t      st;
    logic [7:0] rb;
  } step_t;

  // pending flags drive the status bits, start then address phase then stop
  function automatic regs_t apply_flags(regs_t s);
    regs_t r;
    r = s;
    if (r.start_w) begin
      r.sr1 = r.sr1 | S1_SB;
      r.sr2 = r.sr2 | S2_BUSY | S2_MSL;
    end
    if (r.addr_ph) begin
      r.sr1 = (r.sr1 | S1_ADDR | S1_TXE | S1_BTF) & ~S1_SB;
      r.sr2 = r.sr2 | S2_TRA;
    end
    if (r.stop_w) begin
      r.sr1 = (r.sr1 | S1_STOPF) & ~(S1_ADDR | S1_SB | S1_TXE | S1_BTF);
      r.sr2 = r.sr2 & ~(S2_BUSY | S2_MSL | S2_TRA);
    end
    return r;
  endfunction

  // one byte of an access: fetch with side effects, then merge and store
  function automatic step_t byte_step(regs_t s, logic [6:0] addr, logic wr,
                                      logic [7:0] nb);
    step_t       r;
    logic [15:0] old;
    logic [15:0] merged;
    logic [4:0]  slot;
    r.st   = s;
    r.rb   = 8'h00;
    old    = 16'h0000;
    merged = 16'h0000;
    slot   = addr[6:2];
    if ((addr < WINDOW_END) && !addr[1]) begin
      case (slot)
        SLOT_CR1:   old = s.cr1;
        SLOT_CR2:   old = s.cr2;
        SLOT_OAR1:  old = s.oar1;
        SLOT_OAR2:  old = s.oar2;
        SLOT_DR:    old = {8'h00, s.dr};
        SLOT_SR1: begin
          old = s.sr1;
          if (s.addr_ph && !s.stop_w) old = old | S1_TXE | S1_BTF;
        end
        SLOT_SR2: begin
          old      = s.sr2;
          r.st.sr1 = s.sr1 & ~S1_ADDR;
        end
        SLOT_CCR:   old = s.ccr;
        SLOT_TRISE: old = s.trise;
        default:    old = 16'h0000;
      endcase
      if (wr) begin
        merged = addr[0] ? {nb, old[7:0]} : {old[15:8], nb};
        case (slot)
          SLOT_CR1: begin
            if ((merged & CR_START) != 16'h0000) begin
              r.st.start_w = 1'b1;
              r.st.addr_ph = 1'b0;
              r.st.stop_w  = 1'b0;
            end
            if ((merged & CR_STOP) != 16'h0000) begin
              r.st.start_w = 1'b0;
              r.st.addr_ph = 1'b0;
              r.st.stop_w  = 1'b1;
            end
            r.st.cr1 = merged;
            r.st     = apply_flags(r.st);
          end
          SLOT_CR2:   r.st.cr2  = merged;
          SLOT_OAR1:  r.st.oar1 = merged;
          SLOT_OAR2:  r.st.oar2 = merged;
          SLOT_DR: begin
            r.st.dr = merged[7:0];
            if (r.st.start_w) begin
              r.st.start_w = 1'b0;
              r.st.addr_ph = 1'b1;
            end
            r.st = apply_flags(r.st);
          end
          SLOT_SR1:   r.st.sr1   = r.st.sr1 & merged;
          SLOT_SR2:   r.st.sr2   = merged;
          SLOT_CCR:   r.st.ccr   = merged;
          SLOT_TRISE: r.st.trise = merged;
          default:    r.st       = r.st;
        endcase
      end else begin
        r.rb = addr[0] ? old[15:8] : old[7:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== design/i2c_master_status_registers.sv =====
// ----------------------------------------------------------------------------
// i2c_master_status_registers
// Register window of a simplified I2C master: control, address, data,
// status, clock and rise time registers behind a streaming access port.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one register access per transfer: tuser is the kind
//   (0 read, 1 write), tdata packs the byte offset, the byte count (1 to 4,
//   larger counts act as 4) and the little-endian write bytes.
//   m_axis returns exactly one transfer per access with the read bytes,
//   little endian; writes and unmapped bytes return zero.
// timing
//   an accepted access waits in the input register, where all of its
//   bytes update the register state together as it moves into the
//   output register, which then holds its result
//   throughput is one access per cycle while m_axis_tready_i is high, set
//   by the single pass of byte-lane logic between the input and output registers
// reset
//   all register map registers and pending bus flags clear to zero, both stages empty
// back-pressure
//   while m_axis_tready_i is low the result holds and the input register
//   may still take one more access; after that s_axis_tready_o drops, and
//   state changes only when an access moves into the output register
// ----------------------------------------------------------------------------
module i2c_master_status_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // byte_offset[5:0], access_bytes[8:6],
                                       // write_data[40:9], zero fill
  input  logic        s_axis_tuser_i,  // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // read_data
);
  import i2cms_pkg::*;

  access_t     in_q;
  logic        in_valid_q;
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        advance;
  logic        in_take;
  logic [31:0] rdata;

  // an access moves on once the output register is free or being emptied
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // input register, payload without reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_take || (in_valid_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.wr     <= s_axis_tuser_i;
      in_q.offset <= s_axis_tdata_i[5:0];
      in_q.nbytes <= s_axis_tdata_i[8:6];
      in_q.wdata  <= s_axis_tdata_i[40:9];
    end
  end

  // register state and the byte lanes, committed on advance
  i2cms_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .access_i (in_q),
    .rdata_o  (rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= advance || (out_valid_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= rdata;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled with room downstream");

  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced access lost before output");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.wr) |=> (out_data_q == 32'h0000_0000))
    else $error("write access returned nonzero data");

endmodule

// ===== design/i2cms_regfile.sv =====
// ----------------------------------------------------------------------------
// i2cms_regfile
// Register state of the window and the four byte lanes of one access,
// applied in ascending address order in one combinational pass.
// ----------------------------------------------------------------------------
module i2cms_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  i2cms_pkg::access_t  access_i,
  output logic [31:0]         rdata_o
);
  import i2cms_pkg::*;

  regs_t       regs_q;
  regs_t       regs_d;
  step_t       step [4];
  regs_t       chain [5];
  logic [2:0]  nbytes;
  logic [31:0] rdata;

  assign nbytes = (access_i.nbytes > MAX_BYTES) ? MAX_BYTES : access_i.nbytes;

  always_comb begin
    chain[0] = regs_q;
    rdata    = 32'h0000_0000;
    for (int i = 0; i < 4; i++) begin
      step[i] = byte_step(chain[i], {1'b0, access_i.offset} + 7'(i), access_i.wr,
                          access_i.wdata[8*i +: 8]);
      if (3'(i) < nbytes) begin
        chain[i+1]       = step[i].st;
        rdata[8*i +: 8]  = step[i].rb;
      end else begin
        chain[i+1]       = chain[i];
      end
    end
    regs_d = en_i ? chain[4] : regs_q;
  end

  // writes read back as zero
  assign rdata_o = access_i.wr ? 32'h0000_0000 : rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else begin
      regs_q <= regs_d;
    end
  end

  a_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({regs_q.start_w, regs_q.addr_ph, regs_q.stop_w}))
    else $error("more than one pending bus flag");

  a_addr_no_sb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q.addr_ph |-> ((regs_q.sr1 & S1_SB) == 16'h0000))
    else $error("start bit set during address phase");

endmodule
